### hdl/ccf_pkg.sv
// Shared types and constants for the chat colour code filter.
package ccf_pkg;

   localparam int MaxRes = 8;
   localparam int IdxW   = 3;
   localparam int CountW = 4;
   localparam int QDepth = 2;
   localparam int QPtrW  = 1;
   localparam int QCntW  = 2;

   typedef struct packed {
      logic [MaxRes-1:0][7:0] data;
      logic [CountW-1:0]      count;
      logic                   fin;
   } rec_type;

endpackage

### hdl/ccf_req_if.sv
// Input channel: one text byte per transfer with its end-of-message flag.
interface ccf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

### hdl/ccf_rsp_if.sv
// Result channel: one output byte per transfer with its flags.
interface ccf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       end_of_text;

   modport source (output valid, output out_byte, output byte_valid, output end_of_text,
                   input ready);
   modport sink (input valid, input out_byte, input byte_valid, input end_of_text,
                 output ready);
endinterface

### hdl/chat_colour_code_filter_top.sv
// Top level of the chat colour code filter.
// Rewrites a chat byte stream: colour, bold, reset, reverse and underline codes become
// percent sequences (or are removed in strip mode); outside strip mode, percent and
// backslash are escaped and a slash before a bar is doubled. The front end takes one
// input byte per cycle while its two-entry list queue has room; the back end sends one
// result byte per cycle while the result channel is ready, and an input byte makes 0 to
// 8 result bytes. The single-byte output port of the back end sets the sustained rate.
// Write the registers only while idle.
module chat_colour_code_filter_top
   import ccf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ccf_req_if.sink    req_ch,
   ccf_rsp_if.source  rsp_ch,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [0:0] csr_wr_data
);

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_nonempty;
   rec_type q_data;
   rec_type q_head;

   ccf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_data)
   );

   ccf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .nonempty  (q_nonempty),
      .head      (q_head)
   );

   ccf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_nonempty (q_nonempty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

### hdl/ccf_front.sv
// Front end: config registers, code parser and output byte list builder.
module ccf_front
   import ccf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   ccf_req_if.sink       req_ch,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_index,
   input  logic [0:0]    csr_wr_data,
   input  logic          q_full,
   output logic          q_push,
   output rec_type       q_data
);

   typedef enum logic [7:0] {
      PH_IDLE    = 8'b0000_0001,
      PH_START   = 8'b0000_0010,
      PH_FG1     = 8'b0000_0100,
      PH_FG2     = 8'b0000_1000,
      PH_COMMA_N = 8'b0001_0000,
      PH_COMMA_F = 8'b0010_0000,
      PH_BG1_N   = 8'b0100_0000,
      PH_BG1_F   = 8'b1000_0000
   } phase_type;

   localparam logic [1:0] RegFilterMode  = 2'd0;
   localparam logic [1:0] RegDropColours = 2'd1;
   localparam logic [1:0] RegAppendReset = 2'd2;

   localparam logic [7:0] ChColour = 8'h03;
   localparam logic [7:0] ChBold   = 8'h02;
   localparam logic [7:0] ChReset  = 8'h0f;
   localparam logic [7:0] ChRev1   = 8'h12;
   localparam logic [7:0] ChRev2   = 8'h16;
   localparam logic [7:0] ChUnder  = 8'h1f;
   localparam logic [7:0] ChPct    = 8'h25;
   localparam logic [7:0] ChBslash = 8'h5c;
   localparam logic [7:0] ChSlash  = 8'h2f;
   localparam logic [7:0] ChBar    = 8'h7c;
   localparam logic [7:0] ChComma  = 8'h2c;
   localparam logic [7:0] ChZero   = 8'h30;
   localparam logic [7:0] ChNine   = 8'h39;
   localparam logic [7:0] ChLowN   = 8'h6e;
   localparam logic [7:0] ChUpT    = 8'h54;
   localparam logic [7:0] ChUpV    = 8'h56;
   localparam logic [7:0] ChUpU    = 8'h55;

   logic      mode_ff, mode_in;
   logic      drop_ff, drop_in;
   logic      app_ff, app_in;
   phase_type phase_ff, phase_in;
   logic [3:0] fore_ff, fore_in;
   logic [3:0] back_ff, back_in;
   logic      slash_ff, slash_in;

   logic      accept;
   rec_type   rec;

   function automatic logic [7:0] fore_letter(input logic [3:0] i);
      logic [7:0] c;
      case (i)
         4'd0:    c = "W";
         4'd1:    c = "k";
         4'd2:    c = "b";
         4'd3:    c = "g";
         4'd4:    c = "r";
         4'd5:    c = "y";
         4'd6:    c = "p";
         4'd7:    c = "R";
         4'd8:    c = "Y";
         4'd9:    c = "G";
         4'd10:   c = "c";
         4'd11:   c = "C";
         4'd12:   c = "B";
         4'd13:   c = "P";
         4'd14:   c = "K";
         default: c = "w";
      endcase
      return c;
   endfunction

   function automatic logic [7:0] back_letter(input logic [3:0] i);
      logic [7:0] c;
      case (i)
         4'd0:    c = "x";
         4'd1:    c = "l";
         4'd2:    c = "e";
         4'd3:    c = "h";
         4'd4:    c = "s";
         4'd5:    c = "z";
         4'd6:    c = "q";
         4'd7:    c = "s";
         4'd8:    c = "z";
         4'd9:    c = "h";
         4'd10:   c = "d";
         4'd11:   c = "d";
         4'd12:   c = "e";
         4'd13:   c = "q";
         4'd14:   c = "l";
         default: c = "x";
      endcase
      return c;
   endfunction

   function automatic rec_type put_byte(input rec_type r, input logic [7:0] b);
      rec_type o;
      o = r;
      if (o.count < CountW'(MaxRes)) begin
         o.data[o.count[IdxW-1:0]] = b;
         o.count = o.count + 1'b1;
      end
      return o;
   endfunction

   function automatic rec_type close_code(input rec_type r, input phase_type ph,
                                          input logic [3:0] fv, input logic [3:0] bv,
                                          input logic emit);
      rec_type o;
      o = r;
      if (emit && ph != PH_IDLE) begin
         if (ph == PH_START) begin
            o = put_byte(o, ChPct);
            o = put_byte(o, ChLowN);
         end else begin
            if (ph == PH_FG1 || ph == PH_FG2 || ph == PH_COMMA_F || ph == PH_BG1_F) begin
               o = put_byte(o, ChPct);
               o = put_byte(o, fore_letter(fv));
            end
            if (ph == PH_COMMA_N || ph == PH_COMMA_F || ph == PH_BG1_N || ph == PH_BG1_F)
            begin
               o = put_byte(o, ChPct);
               o = put_byte(o, back_letter(bv));
            end
         end
      end
      return o;
   endfunction

   function automatic logic [3:0] times_ten_add(input logic [3:0] v, input logic [3:0] d);
      logic [6:0] t;
      t = {v, 3'b000} + {2'b00, v, 1'b0};
      return t[3:0] + d;
   endfunction

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !q_full;

   always_comb begin
      logic [7:0] b;
      logic       digit;
      logic [3:0] d;
      logic       consumed;
      logic       emit;
      logic       was_slash;
      b         = req_ch.text_byte;
      digit     = (b >= ChZero) && (b <= ChNine);
      d         = digit ? b[3:0] : 4'd0;
      consumed  = 1'b1;
      emit      = !mode_ff && !drop_ff;
      rec       = '0;
      phase_in  = phase_ff;
      fore_in   = fore_ff;
      back_in   = back_ff;
      slash_in  = slash_ff;
      was_slash = 1'b0;
      case (phase_ff)
         PH_START: begin
            if (digit) begin
               fore_in  = d;
               phase_in = PH_FG1;
            end else if (b == ChComma) begin
               back_in  = 4'd0;
               phase_in = PH_COMMA_N;
            end else begin
               consumed = 1'b0;
            end
         end
         PH_FG1: begin
            if (digit) begin
               fore_in  = times_ten_add(fore_ff, d);
               phase_in = PH_FG2;
            end else if (b == ChComma) begin
               back_in  = 4'd0;
               phase_in = PH_COMMA_F;
            end else begin
               consumed = 1'b0;
            end
         end
         PH_FG2: begin
            if (b == ChComma) begin
               back_in  = 4'd0;
               phase_in = PH_COMMA_F;
            end else begin
               consumed = 1'b0;
            end
         end
         PH_COMMA_N, PH_COMMA_F: begin
            if (digit) begin
               back_in  = d;
               phase_in = (phase_ff == PH_COMMA_N) ? PH_BG1_N : PH_BG1_F;
            end else begin
               consumed = 1'b0;
            end
         end
         PH_BG1_N, PH_BG1_F: begin
            if (digit) begin
               back_in  = times_ten_add(back_ff, d);
               rec      = close_code(rec, phase_ff, fore_in, back_in, emit);
               phase_in = PH_IDLE;
            end else begin
               consumed = 1'b0;
            end
         end
         default: begin
            consumed = 1'b0;
         end
      endcase

      if (consumed) begin
         slash_in = 1'b0;
      end else begin
         if (phase_in != PH_IDLE) begin
            rec      = close_code(rec, phase_in, fore_in, back_in, emit);
            phase_in = PH_IDLE;
         end
         was_slash = slash_in;
         slash_in  = (b == ChSlash);
         if (b == ChColour) begin
            phase_in = PH_START;
            fore_in  = 4'd0;
            back_in  = 4'd0;
            slash_in = 1'b0;
         end else if (mode_ff) begin
            if (!(b == ChBold || b == ChReset || b == ChRev1 || b == ChRev2 || b == ChUnder))
               rec = put_byte(rec, b);
         end else begin
            case (b)
               ChBold: begin
                  rec = put_byte(rec, ChPct);
                  rec = put_byte(rec, ChUpT);
               end
               ChReset: begin
                  rec = put_byte(rec, ChPct);
                  rec = put_byte(rec, ChLowN);
               end
               ChRev1, ChRev2: begin
                  rec = put_byte(rec, ChPct);
                  rec = put_byte(rec, ChUpV);
               end
               ChUnder: begin
                  rec = put_byte(rec, ChPct);
                  rec = put_byte(rec, ChUpU);
               end
               ChPct: begin
                  rec = put_byte(rec, ChBslash);
                  rec = put_byte(rec, ChPct);
               end
               ChBslash: begin
                  rec = put_byte(rec, ChBslash);
                  rec = put_byte(rec, ChBslash);
               end
               default: begin
                  if (b == ChBar && was_slash)
                     rec = put_byte(rec, ChSlash);
                  rec = put_byte(rec, b);
               end
            endcase
         end
      end

      if (req_ch.final_byte) begin
         if (phase_in != PH_IDLE)
            rec = close_code(rec, phase_in, fore_in, back_in, emit);
         if (!mode_ff && app_ff) begin
            rec = put_byte(rec, ChPct);
            rec = put_byte(rec, ChLowN);
         end
         phase_in = PH_IDLE;
         fore_in  = 4'd0;
         back_in  = 4'd0;
         slash_in = 1'b0;
      end
      rec.fin = req_ch.final_byte;
   end

   assign q_push = accept && (rec.count != '0 || req_ch.final_byte);
   assign q_data = rec;

   always_comb begin
      mode_in = mode_ff;
      drop_in = drop_ff;
      app_in  = app_ff;
      if (csr_wr_en) begin
         case (csr_index)
            RegFilterMode:  mode_in = csr_wr_data[0];
            RegDropColours: drop_in = csr_wr_data[0];
            RegAppendReset: app_in  = csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         drop_ff  <= 1'b0;
         app_ff   <= 1'b0;
         phase_ff <= PH_IDLE;
         fore_ff  <= 4'd0;
         back_ff  <= 4'd0;
         slash_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         drop_ff <= drop_in;
         app_ff  <= app_in;
         if (accept) begin
            phase_ff <= phase_in;
            fore_ff  <= fore_in;
            back_ff  <= back_in;
            slash_ff <= slash_in;
         end
      end
   end

`ifndef SYNTH
   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.final_byte |=> phase_ff == PH_IDLE && !slash_ff)
      else $error("parser not idle after message end");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into full queue");
   a_start_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_START |-> fore_ff == 4'd0 && back_ff == 4'd0 && !slash_ff)
      else $error("colour code opened with stale values");
`endif

endmodule

### hdl/ccf_queue.sv
// Two-entry queue of output byte lists between the front and back ends.
module ccf_queue
   import ccf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    nonempty,
   output rec_type head
);

   rec_type           entry_ff [QDepth];
   logic [QPtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]  count_ff, count_in;

   assign full     = (count_ff == QCntW'(QDepth));
   assign nonempty = (count_ff != '0);
   assign head     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCntW'(push) - QCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hdl/ccf_back.sv
// Back end: walks one byte list and sends its bytes on the result channel.
module ccf_back
   import ccf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_nonempty,
   input  rec_type   q_head,
   output logic      q_pop,
   ccf_rsp_if.source rsp_ch
);

   rec_type          cur_ff, cur_in;
   logic [IdxW-1:0]  idx_ff, idx_in;
   logic             busy_ff, busy_in;
   logic             last;
   logic             xfer;

   assign xfer  = rsp_ch.valid && rsp_ch.ready;
   assign last  = (cur_ff.count == '0) ||
                  ({1'b0, idx_ff} == cur_ff.count - 1'b1);
   assign q_pop = q_nonempty && (!busy_ff || (xfer && last));

   assign rsp_ch.valid       = busy_ff;
   assign rsp_ch.byte_valid  = (cur_ff.count != '0);
   assign rsp_ch.out_byte    = (cur_ff.count != '0) ? cur_ff.data[idx_ff] : 8'd0;
   assign rsp_ch.end_of_text = cur_ff.fin && last;

   always_comb begin
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (q_pop) begin
         cur_in  = q_head;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (xfer) begin
         if (last)
            busy_in = 1'b0;
         else
            idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
   end

`ifndef SYNTH
   a_bare_is_end: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !rsp_ch.byte_valid |-> rsp_ch.end_of_text)
      else $error("bare marker not at message end");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff && cur_ff.count != '0 |-> {1'b0, idx_ff} < cur_ff.count)
      else $error("byte index beyond list");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !rsp_ch.ready |=> $stable(idx_ff) && busy_ff)
      else $error("list position moved while stalled");
`endif

endmodule
